// File: rtl/core/offset_window_count_table_top_defines.svh
// Assertion macros shared by the checker of the offset window count table.
`ifndef OFFSET_WINDOW_COUNT_TABLE_TOP_DEFINES_SVH
`define OFFSET_WINDOW_COUNT_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define OWCT_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define OWCT_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/owct_pkg.sv
// Types, constants and ring-index helpers of the offset window count table.
`default_nettype none
package owct_pkg;

	// Window capacity and derived widths
	localparam int DEPTH  = 64;
	localparam int AW     = $clog2(DEPTH);
	localparam int LW     = $clog2(DEPTH + 1);
	localparam int QDEPTH = 2;
	localparam int VW     = 32;
	localparam int IW     = 16;
	localparam int EW     = 17;
	localparam int SW     = 38;

	typedef logic [AW-1:0] addr_t;
	typedef logic [AW:0]   addrx_t;
	typedef logic [LW-1:0] len_t;

	localparam addrx_t DEPTH_W = addrx_t'(DEPTH);

	// Request commands
	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_DUMP  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	// Classified operations handed from front to back
	typedef enum logic [2:0] {
		OP_RD,
		OP_RD_NONE,
		OP_WR_FIRST,
		OP_WR_REPLACE,
		OP_WR_GROW,
		OP_REFUSE,
		OP_DUMP,
		OP_CLEAR
	} op_t;

	// One classified request; geometry fields hold the state after the request
	typedef struct packed {
		op_t             op;
		addr_t           addr;
		addr_t           fill_addr;
		addr_t           fill_cnt;
		addr_t           head;
		logic [VW-1:0]   value;
		logic [IW-1:0]   base;
		len_t            len;
		logic            empty;
	} req_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_RD_DATA,
		ST_RMW,
		ST_FILL,
		ST_GROW_WR,
		ST_DUMP
	} bst_t;

	// (a + b) mod DEPTH for a, b below DEPTH
	function automatic addr_t wrap_add(addr_t a, addr_t b);
		addrx_t s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	// (a - b) mod DEPTH for a, b below DEPTH
	function automatic addr_t wrap_sub(addr_t a, addr_t b);
		addrx_t s;
		s = {1'b0, a} - {1'b0, b};
		if (a < b) begin
			s = s + DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/offset_window_count_table_top.sv
// Flow: an accepted request enters the queue; the back end pops it in ST_IDLE and handles it in ST_RUN,
// which emits clear, first-write, refused and out-of-window results; reads go on to ST_RD_DATA,
// overwrites to ST_RMW, growing or base-lowering writes through ST_FILL to ST_GROW_WR, dumps to ST_DUMP.
// The back-end sequencer walks the counter RAM one entry per cycle in ST_FILL and ST_DUMP; a 2-deep
// queue decouples start, so requests are taken while the back end is busy; results never stall.
// Reset (arst_n low, asynchronous): empty window, base 0, total 0, no result pending.
`default_nettype none
module offset_window_count_table_top import owct_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [1:0]           cmd,
	input  wire logic [IW-1:0]        entry_index,
	input  wire logic signed [VW-1:0] entry_value,
	output logic                      result_valid,
	output logic signed [VW-1:0]      read_value,
	output logic        [IW-1:0]      pair_id,
	output logic signed [VW-1:0]      pair_value,
	output logic                      pair_valid,
	output logic                      last,
	output logic                      is_empty,
	output logic        [IW-1:0]      window_base,
	output logic        [EW-1:0]      window_end,
	output logic signed [SW-1:0]      total_sum,
	output logic                      status
);

	logic accept;
	req_t push_req;
	req_t pop_req;
	logic q_full;
	logic q_not_empty;
	logic q_pop;

	// Request handshake: stall only while the queue is full
	assign busy   = q_full;
	assign accept = start && !q_full;

	owct_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.cmd         (cmd),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.req         (push_req)
	);

	owct_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_req  (push_req),
		.pop       (q_pop),
		.pop_req   (pop_req),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	owct_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_not_empty),
		.q_req        (pop_req),
		.pop          (q_pop),
		.result_valid (result_valid),
		.read_value   (read_value),
		.pair_id      (pair_id),
		.pair_value   (pair_value),
		.pair_valid   (pair_valid),
		.last         (last),
		.is_empty     (is_empty),
		.window_base  (window_base),
		.window_end   (window_end),
		.total_sum    (total_sum),
		.status       (status)
	);

endmodule
`default_nettype wire

// File: rtl/core/owct_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module owct_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: rtl/core/owct_front.sv
// Front end: tracks window geometry and classifies each accepted request.
`default_nettype none
module owct_front import owct_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 accept,
	input  wire logic [1:0]           cmd,
	input  wire logic [IW-1:0]        entry_index,
	input  wire logic signed [VW-1:0] entry_value,
	output req_t                      req
);

	logic [IW-1:0] base_q, base_d;
	len_t          len_q, len_d;
	addr_t         head_q, head_d;
	logic          empty_q, empty_d;

	logic [IW:0]   diff;
	logic          above;
	logic [IW-1:0] pos16;
	addr_t         pos_a;
	logic          in_win;
	logic          pos_fits;
	logic [IW-1:0] d16;
	logic          lower_fits;
	addr_t         low_head;

	// Position of the id relative to the window
	always_comb begin
		diff       = {1'b0, entry_index} - {1'b0, base_q};
		above      = ~diff[IW];
		pos16      = diff[IW-1:0];
		pos_a      = pos16[AW-1:0];
		in_win     = above && (pos16 < IW'(len_q));
		pos_fits   = pos16 < IW'(DEPTH);
		d16        = base_q - entry_index;
		lower_fits = (EW'(len_q) + {1'b0, d16}) <= EW'(DEPTH);
		low_head   = wrap_sub(head_q, d16[AW-1:0]);
	end

	// Classification and next geometry
	always_comb begin
		base_d        = base_q;
		len_d         = len_q;
		head_d        = head_q;
		empty_d       = empty_q;
		req.op        = OP_RD_NONE;
		req.addr      = head_q;
		req.fill_addr = head_q;
		req.fill_cnt  = '0;
		req.value     = entry_value;
		unique case (cmd_t'(cmd))
			CMD_READ: begin
				if (in_win) begin
					req.op   = OP_RD;
					req.addr = wrap_add(head_q, pos_a);
				end
			end
			CMD_WRITE: begin
				priority if (empty_q || (len_q == '0)) begin
					req.op  = OP_WR_FIRST;
					base_d  = entry_index;
					len_d   = LW'(1);
					empty_d = 1'b0;
				end else if (above) begin
					priority if (in_win) begin
						req.op   = OP_WR_REPLACE;
						req.addr = wrap_add(head_q, pos_a);
					end else if (!pos_fits) begin
						req.op = OP_REFUSE;
					end else begin
						// grow upward: zero the gap, then write the new top entry
						req.op        = OP_WR_GROW;
						req.addr      = wrap_add(head_q, pos_a);
						req.fill_addr = wrap_add(head_q, len_q[AW-1:0]);
						req.fill_cnt  = pos_a - len_q[AW-1:0];
						len_d         = LW'(pos16) + LW'(1);
					end
				end else begin
					if (!lower_fits) begin
						req.op = OP_REFUSE;
					end else begin
						// lower the base: ring head moves down, gap above it is zeroed
						req.op        = OP_WR_GROW;
						head_d        = low_head;
						req.addr      = low_head;
						req.fill_addr = wrap_add(low_head, AW'(1));
						req.fill_cnt  = d16[AW-1:0] - AW'(1);
						len_d         = len_q + LW'(d16);
						base_d        = entry_index;
					end
				end
			end
			CMD_DUMP: begin
				req.op = OP_DUMP;
			end
			CMD_CLEAR: begin
				req.op  = OP_CLEAR;
				base_d  = '0;
				len_d   = '0;
				empty_d = 1'b1;
			end
			default: begin
				req.op = OP_RD_NONE;
			end
		endcase
		req.head  = head_d;
		req.base  = base_d;
		req.len   = len_d;
		req.empty = empty_d;
	end

	// Geometry registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			len_q   <= '0;
			head_q  <= '0;
			empty_q <= 1'b1;
		end else if (accept) begin
			base_q  <= base_d;
			len_q   <= len_d;
			head_q  <= head_d;
			empty_q <= empty_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/owct_queue.sv
// Short request queue between front and back end.
`default_nettype none
module owct_queue import owct_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  req_t      push_req,
	input  wire logic pop,
	output req_t      pop_req,
	output logic      not_empty,
	output logic      full
);

	localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW = $clog2(QDEPTH + 1);

	req_t             slot_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == QCW'(QDEPTH));
	assign pop_req   = slot_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_req;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/owct_back.sv
// Back end: counter RAM, running total, fill and dump sequencer, result registers.
`default_nettype none
module owct_back import owct_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_valid,
	input  req_t                      q_req,
	output logic                      pop,
	output logic                      result_valid,
	output logic signed [VW-1:0]      read_value,
	output logic        [IW-1:0]      pair_id,
	output logic signed [VW-1:0]      pair_value,
	output logic                      pair_valid,
	output logic                      last,
	output logic                      is_empty,
	output logic        [IW-1:0]      window_base,
	output logic        [EW-1:0]      window_end,
	output logic signed [SW-1:0]      total_sum,
	output logic                      status
);

	bst_t                 state_q, state_d;
	req_t                 cur_q, cur_d;
	logic signed [SW-1:0] total_q, total_d;
	len_t                 k_q, k_d;
	addr_t                ptr_q, ptr_d;
	addr_t                cnt_q, cnt_d;
	logic                 pend_v_q, pend_v_d;
	logic [IW-1:0]        pend_id_q, pend_id_d;
	logic [VW-1:0]        pend_val_q, pend_val_d;
	logic                 rd_v_s1, rd_v_d;
	logic [IW-1:0]        id_s1, id_d;

	logic                 ram_we;
	addr_t                ram_waddr;
	logic [VW-1:0]        ram_wdata;
	addr_t                ram_raddr;
	logic [VW-1:0]        ram_rdata;

	logic signed [SW-1:0] val38;
	logic signed [SW-1:0] old38;

	logic                 emit;
	logic [VW-1:0]        o_read;
	logic [IW-1:0]        o_pid;
	logic [VW-1:0]        o_pval;
	logic                 o_pvalid;
	logic                 o_last;
	logic                 o_status;

	logic                 result_valid_q;
	logic [VW-1:0]        read_value_q;
	logic [IW-1:0]        pair_id_q;
	logic [VW-1:0]        pair_value_q;
	logic                 pair_valid_q;
	logic                 last_q;
	logic                 is_empty_q;
	logic [IW-1:0]        window_base_q;
	logic [EW-1:0]        window_end_q;
	logic [SW-1:0]        total_sum_q;
	logic                 status_q;

	// Counter store
	owct_ram #(
		.WIDTH (VW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign val38 = {{(SW-VW){cur_q.value[VW-1]}}, cur_q.value};
	assign old38 = {{(SW-VW){ram_rdata[VW-1]}}, ram_rdata};

	// Sequencer: next state, RAM control and result selection
	always_comb begin
		state_d    = state_q;
		cur_d      = cur_q;
		total_d    = total_q;
		k_d        = k_q;
		ptr_d      = ptr_q;
		cnt_d      = cnt_q;
		pend_v_d   = pend_v_q;
		pend_id_d  = pend_id_q;
		pend_val_d = pend_val_q;
		rd_v_d     = 1'b0;
		id_d       = id_s1;
		pop        = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = cur_q.addr;
		ram_wdata  = cur_q.value;
		ram_raddr  = cur_q.addr;
		emit       = 1'b0;
		o_read     = '0;
		o_pid      = '0;
		o_pval     = '0;
		o_pvalid   = 1'b0;
		o_last     = 1'b1;
		o_status   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					pop     = 1'b1;
					cur_d   = q_req;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				unique case (cur_q.op)
					OP_RD: begin
						state_d = ST_RD_DATA;
					end
					OP_RD_NONE: begin
						emit    = 1'b1;
						state_d = ST_IDLE;
					end
					OP_WR_FIRST: begin
						ram_we  = 1'b1;
						total_d = val38;
						emit    = 1'b1;
						state_d = ST_IDLE;
					end
					OP_WR_REPLACE: begin
						state_d = ST_RMW;
					end
					OP_WR_GROW: begin
						ptr_d   = cur_q.fill_addr;
						cnt_d   = cur_q.fill_cnt;
						state_d = (cur_q.fill_cnt == '0) ? ST_GROW_WR : ST_FILL;
					end
					OP_REFUSE: begin
						o_status = 1'b1;
						emit     = 1'b1;
						state_d  = ST_IDLE;
					end
					OP_DUMP: begin
						k_d      = '0;
						ptr_d    = cur_q.head;
						pend_v_d = 1'b0;
						state_d  = ST_DUMP;
					end
					OP_CLEAR: begin
						total_d = '0;
						emit    = 1'b1;
						state_d = ST_IDLE;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_RD_DATA: begin
				o_read  = ram_rdata;
				emit    = 1'b1;
				state_d = ST_IDLE;
			end
			ST_RMW: begin
				// old value is on the read port now
				ram_we  = 1'b1;
				total_d = total_q - old38 + val38;
				emit    = 1'b1;
				state_d = ST_IDLE;
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = '0;
				ptr_d     = wrap_add(ptr_q, AW'(1));
				cnt_d     = cnt_q - AW'(1);
				if (cnt_q == AW'(1)) begin
					state_d = ST_GROW_WR;
				end
			end
			ST_GROW_WR: begin
				ram_we  = 1'b1;
				total_d = total_q + val38;
				emit    = 1'b1;
				state_d = ST_IDLE;
			end
			ST_DUMP: begin
				// issue one read per cycle along the window
				ram_raddr = ptr_q;
				if (k_q < cur_q.len) begin
					rd_v_d = 1'b1;
					id_d   = cur_q.base + IW'(k_q);
					k_d    = k_q + LW'(1);
					ptr_d  = wrap_add(ptr_q, AW'(1));
				end
				// hold back one nonzero pair so the final one can carry last
				if (rd_v_s1) begin
					if (ram_rdata != '0) begin
						if (pend_v_q) begin
							emit     = 1'b1;
							o_pid    = pend_id_q;
							o_pval   = pend_val_q;
							o_pvalid = 1'b1;
							o_last   = 1'b0;
						end
						pend_v_d   = 1'b1;
						pend_id_d  = id_s1;
						pend_val_d = ram_rdata;
					end
				end else if (k_q >= cur_q.len) begin
					emit = 1'b1;
					if (pend_v_q) begin
						o_pid    = pend_id_q;
						o_pval   = pend_val_q;
						o_pvalid = 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			total_q        <= '0;
			pend_v_q       <= 1'b0;
			rd_v_s1        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			total_q        <= total_d;
			pend_v_q       <= pend_v_d;
			rd_v_s1        <= rd_v_d;
			result_valid_q <= emit;
		end
	end

	// Working payload
	always_ff @(posedge clk) begin
		cur_q      <= cur_d;
		k_q        <= k_d;
		ptr_q      <= ptr_d;
		cnt_q      <= cnt_d;
		pend_id_q  <= pend_id_d;
		pend_val_q <= pend_val_d;
		id_s1      <= id_d;
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (emit) begin
			read_value_q  <= o_read;
			pair_id_q     <= o_pid;
			pair_value_q  <= o_pval;
			pair_valid_q  <= o_pvalid;
			last_q        <= o_last;
			is_empty_q    <= cur_q.empty;
			window_base_q <= cur_q.base;
			window_end_q  <= {1'b0, cur_q.base} + EW'(cur_q.len);
			total_sum_q   <= total_d;
			status_q      <= o_status;
		end
	end

	assign result_valid = result_valid_q;
	assign read_value   = read_value_q;
	assign pair_id      = pair_id_q;
	assign pair_value   = pair_value_q;
	assign pair_valid   = pair_valid_q;
	assign last         = last_q;
	assign is_empty     = is_empty_q;
	assign window_base  = window_base_q;
	assign window_end   = window_end_q;
	assign total_sum    = total_sum_q;
	assign status       = status_q;

endmodule
`default_nettype wire

// File: rtl/core/owct_chk.sv
// Port-level checker for the offset window count table, bound to the top level.
`default_nettype none
`include "offset_window_count_table_top_defines.svh"
module owct_chk import owct_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 result_valid,
	input wire logic signed [VW-1:0] read_value,
	input wire logic                 pair_valid,
	input wire logic                 last,
	input wire logic                 is_empty,
	input wire logic        [IW-1:0] window_base,
	input wire logic        [EW-1:0] window_end,
	input wire logic signed [SW-1:0] total_sum,
	input wire logic                 status
);

	// Only dump pairs may leave a request open
	`OWCT_ASSERT_IMP(a_open_is_pair, clk, arst_n, result_valid && !last, pair_valid,
		"non-final result without a pair")

	// Once a dump has emitted a pair, a result strobed right after it also carries a pair
	`OWCT_ASSERT_NXT(a_dump_stays_pair, clk, arst_n, result_valid && !last,
		!result_valid || pair_valid, "dump lost its pending pair")

	// A refused write reports nothing else
	`OWCT_ASSERT_IMP(a_refuse_clean, clk, arst_n, result_valid && status,
		last && !pair_valid && (read_value == 32'sd0), "refused write with extra fields")

	// Empty table means base, end and total are all zero
	`OWCT_ASSERT_IMP(a_empty_geom, clk, arst_n, result_valid && is_empty,
		(window_base == 16'd0) && (window_end == 17'd0) && (total_sum == 38'sd0),
		"empty table with nonzero geometry")

	// Window never shrinks below the base nor grows past capacity
	`OWCT_ASSERT_IMP(a_window_span, clk, arst_n, result_valid,
		(window_end >= EW'(window_base)) && ((window_end - EW'(window_base)) <= EW'(DEPTH)),
		"window span out of range")

endmodule

bind offset_window_count_table_top owct_chk u_chk (.*);
`default_nettype wire

// File: bench/offset_window_count_table_top_tb.sv
// Testbench of the offset window count table: directed and random requests, scoreboard check.
module offset_window_count_table_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import owct_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 7;
	localparam int RANDOM_REQS    = 385;
	localparam int DRAIN_CYCLES   = DEPTH + 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SHOWN_ERRORS   = 10;

	// One result as it appears on the result ports
	typedef struct packed {
		logic [VW-1:0] read_value;
		logic [IW-1:0] pair_id;
		logic [VW-1:0] pair_value;
		logic          pair_valid;
		logic          last;
		logic          is_empty;
		logic [IW-1:0] window_base;
		logic [EW-1:0] window_end;
		logic [SW-1:0] total_sum;
		logic          status;
	} table_res_t;

	// Shadow of the counter window plus the queue of results still owed by the block
	class window_scoreboard;
		logic [VW-1:0] counters [DEPTH];
		int unsigned   base_id;
		int unsigned   win_len;
		bit            empty;
		longint        total;
		table_res_t    pending[$];
		int            errors;

		function new();
			clear_table();
			errors = 0;
		endfunction

		function void clear_table();
			foreach (counters[k]) counters[k] = '0;
			base_id = 0;
			win_len = 0;
			empty   = 1'b1;
			total   = 0;
		endfunction

		// Append one expected result behind those already owed
		function void owe_result(table_res_t r);
			pending.insert(pending.size(), r);
		endfunction

		// Result fields; geometry and total reflect the state after the request
		function table_res_t make_res(logic [VW-1:0] rv, logic [IW-1:0] pid,
				logic [VW-1:0] pv, logic valid, logic fin, logic st);
			table_res_t r;
			r.read_value  = rv;
			r.pair_id     = pid;
			r.pair_value  = pv;
			r.pair_valid  = valid;
			r.last        = fin;
			r.is_empty    = empty;
			r.window_base = base_id[IW-1:0];
			r.window_end  = EW'(base_id + win_len);
			r.total_sum   = total[SW-1:0];
			r.status      = st;
			return r;
		endfunction

		// Store one counter, growing or shifting the window; returns 1 when refused
		function logic write_entry(int unsigned idx, logic [VW-1:0] val);
			int unsigned pos;
			int unsigned gap;
			if (empty || win_len == 0) begin
				counters[0] = val;
				base_id     = idx;
				win_len     = 1;
				empty       = 1'b0;
				total       = longint'($signed(val));
				return 1'b0;
			end
			if (idx >= base_id) begin
				pos = idx - base_id;
				if (pos < win_len) begin
					total         = total - longint'($signed(counters[pos]));
					counters[pos] = val;
					total         = total + longint'($signed(val));
					return 1'b0;
				end
				if (pos >= DEPTH) return 1'b1;
				for (int unsigned k = win_len; k < pos; k++) counters[k] = '0;
				counters[pos] = val;
				win_len       = pos + 1;
				total         = total + longint'($signed(val));
				return 1'b0;
			end
			// below the base: move everything up by the gap
			gap = base_id - idx;
			if (win_len + gap > DEPTH) return 1'b1;
			for (int unsigned k = win_len; k > 0; k--) counters[k - 1 + gap] = counters[k - 1];
			for (int unsigned k = 0; k < gap; k++) counters[k] = '0;
			counters[0] = val;
			win_len     = win_len + gap;
			base_id     = idx;
			total       = total + longint'($signed(val));
			return 1'b0;
		endfunction

		// Accepted request: update the shadow and queue what the block must return
		function void note_request(cmd_t c, logic [IW-1:0] idx, logic [VW-1:0] val);
			table_res_t    dumped[$];
			logic [VW-1:0] rv;
			logic          st;
			int unsigned   i;
			i = idx;
			case (c)
				CMD_READ: begin
					rv = '0;
					if (i >= base_id && i - base_id < win_len) rv = counters[i - base_id];
					owe_result(make_res(rv, '0, '0, 1'b0, 1'b1, 1'b0));
				end
				CMD_WRITE: begin
					st = write_entry(i, val);
					owe_result(make_res('0, '0, '0, 1'b0, 1'b1, st));
				end
				CMD_DUMP: begin
					for (int unsigned k = 0; k < win_len; k++) begin
						if (counters[k] != '0)
							dumped.insert(dumped.size(), make_res('0, IW'(base_id + k),
								counters[k], 1'b1, 1'b0, 1'b0));
					end
					if (dumped.size() == 0) begin
						owe_result(make_res('0, '0, '0, 1'b0, 1'b1, 1'b0));
					end else begin
						dumped[dumped.size() - 1].last = 1'b1;
						foreach (dumped[k]) owe_result(dumped[k]);
					end
				end
				default: begin
					clear_table();
					owe_result(make_res('0, '0, '0, 1'b0, 1'b1, 1'b0));
				end
			endcase
		endfunction

		function string fmt(table_res_t r);
			return $sformatf("rd=%h id=%h pv=%h pvld=%b last=%b empty=%b base=%h end=%h sum=%h st=%b",
				r.read_value, r.pair_id, r.pair_value, r.pair_valid, r.last, r.is_empty,
				r.window_base, r.window_end, r.total_sum, r.status);
		endfunction

		// Compare one strobed result with the oldest outstanding one
		function void check_result(table_res_t got);
			table_res_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= SHOWN_ERRORS)
					$display("%0t: result with nothing outstanding: %s", $time, fmt(got));
				return;
			end
			want = pending.pop_front();
			if (got.read_value !== want.read_value || got.pair_id !== want.pair_id ||
					got.pair_value !== want.pair_value || got.pair_valid !== want.pair_valid ||
					got.last !== want.last || got.is_empty !== want.is_empty ||
					got.window_base !== want.window_base || got.window_end !== want.window_end ||
					got.total_sum !== want.total_sum || got.status !== want.status) begin
				errors++;
				if (errors <= SHOWN_ERRORS) begin
					$display("%0t: result mismatch", $time);
					$display("  expected %s", fmt(want));
					$display("  actual   %s", fmt(got));
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [1:0]           cmd;
	logic [IW-1:0]        entry_index;
	logic signed [VW-1:0] entry_value;
	logic                 result_valid;
	logic signed [VW-1:0] read_value;
	logic [IW-1:0]        pair_id;
	logic signed [VW-1:0] pair_value;
	logic                 pair_valid;
	logic                 last;
	logic                 is_empty;
	logic [IW-1:0]        window_base;
	logic [EW-1:0]        window_end;
	logic signed [SW-1:0] total_sum;
	logic                 status;

	window_scoreboard sb = new;
	bit               steady = 1'b0;
	int               idle_cycles = 0;

	offset_window_count_table_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.result_valid (result_valid),
		.read_value   (read_value),
		.pair_id      (pair_id),
		.pair_value   (pair_value),
		.pair_valid   (pair_valid),
		.last         (last),
		.is_empty     (is_empty),
		.window_base  (window_base),
		.window_end   (window_end),
		.total_sum    (total_sum),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// Result monitor: every strobe is one result
	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_result(table_res_t'{read_value, pair_id, pair_value, pair_valid, last,
				is_empty, window_base, window_end, total_sum, status});
	end

	// Watchdog on cycles with neither a request nor a result accepted
	always @(posedge clk) begin
		if ((start && !busy) || result_valid) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL offset_window_count_table_top");
				$finish;
			end
		end
	end

	// Present one request, hold it until accepted, then maybe idle a little
	task automatic send_req(input cmd_t c, input logic [IW-1:0] idx, input logic [VW-1:0] val);
		start       <= 1'b1;
		cmd         <= c;
		entry_index <= idx;
		entry_value <= val;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(c, idx, val);
		if (!steady && $urandom_range(99) < 16) begin
			start <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
		end
	endtask

	// Ids near the window and its limits, with some anywhere in the id space
	function automatic logic [IW-1:0] pick_index();
		int b;
		int l;
		int x;
		b = sb.base_id;
		l = sb.win_len;
		if (sb.empty || $urandom_range(9) == 0) return IW'($urandom);
		case ($urandom_range(7))
			0: x = b + l - DEPTH - int'($urandom_range(1));
			1: x = b + DEPTH - 1 + int'($urandom_range(1));
			2: x = b - 1 - int'($urandom_range(7));
			3: x = b + l + int'($urandom_range(7));
			default: x = b + int'($urandom_range(l - 1));
		endcase
		return IW'(x);
	endfunction

	// Zeros often, so that dumps skip entries; extremes and small values too
	function automatic logic [VW-1:0] rand_value();
		case ($urandom_range(9))
			0, 1: return '0;
			2: begin
				case ($urandom_range(2))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			3: return VW'(int'($urandom_range(16)) - 8);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int   roll;
		cmd_t c;
		arst_n      <= 1'b0;
		start       <= 1'b0;
		cmd         <= CMD_READ;
		entry_index <= '0;
		entry_value <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// read and dump of an empty table
		send_req(CMD_READ, 16'h0000, '0);
		send_req(CMD_DUMP, 16'h0000, '0);
		// window at the top of the id space, filled by one shift down
		send_req(CMD_WRITE, 16'hFFFF, 32'h7FFF_FFFF);
		send_req(CMD_WRITE, 16'hFFC0, 32'h8000_0000);
		send_req(CMD_WRITE, 16'hFFBF, 32'h0000_0001);
		send_req(CMD_READ, 16'hFFFF, '0);
		send_req(CMD_READ, 16'hFFDC, '0);
		send_req(CMD_READ, 16'h0000, '0);
		send_req(CMD_DUMP, 16'h0000, '0);
		send_req(CMD_WRITE, 16'hFFDC, 32'hFFFF_FFFF);
		send_req(CMD_WRITE, 16'hFFFF, 32'h0000_0000);
		send_req(CMD_DUMP, 16'h0000, '0);
		send_req(CMD_CLEAR, 16'h0000, '0);
		send_req(CMD_DUMP, 16'h0000, '0);
		// base 0: refused growth, then growth to full depth
		send_req(CMD_WRITE, 16'h0000, 32'h0000_0005);
		send_req(CMD_WRITE, 16'h0040, 32'h0000_0009);
		send_req(CMD_WRITE, 16'h003F, 32'hFFFF_FFF9);
		send_req(CMD_READ, 16'h003F, '0);
		send_req(CMD_READ, 16'h0040, '0);
		send_req(CMD_CLEAR, 16'h0000, '0);
		// first write of zero, all-zero dump, shift down to the limit
		send_req(CMD_WRITE, 16'h0064, 32'h0000_0000);
		send_req(CMD_DUMP, 16'h0000, '0);
		send_req(CMD_WRITE, 16'h0028, 32'h0000_0003);
		send_req(CMD_WRITE, 16'h0024, 32'h0000_0001);
		send_req(CMD_WRITE, 16'h0025, 32'h5555_AAAA);
		send_req(CMD_DUMP, 16'h0000, '0);

		for (int n = 0; n < RANDOM_REQS; n++) begin
			steady = (n >= 150 && n < 250);
			// hold off until the block has returned everything
			if (n == 120) begin
				start <= 1'b0;
				while (sb.pending.size() != 0) @(posedge clk);
			end
			roll = $urandom_range(99);
			if (roll < 3) c = CMD_CLEAR;
			else if (roll < 13) c = CMD_DUMP;
			else if (roll < 43) c = CMD_READ;
			else c = CMD_WRITE;
			send_req(c, pick_index(), rand_value());
		end

		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("PASS offset_window_count_table_top");
		end else begin
			$display("FAIL offset_window_count_table_top");
		end
		$finish;
	end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/owct_pkg.sv
rtl/core/owct_ram.sv
rtl/core/owct_front.sv
rtl/core/owct_queue.sv
rtl/core/owct_back.sv
rtl/core/offset_window_count_table_top.sv
rtl/core/owct_chk.sv
bench/offset_window_count_table_top_tb.sv
